>>> hw/rtl/msbs_pkg.sv
package msbs_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_ENTRIES_DEF     = 16;
    localparam int MAX_PATTERN_LEN_DEF = 32;
    localparam int MAX_SCAN_BYTES_DEF  = 2047;

    // Field widths fixed by the stream format
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 4;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 4;
    localparam int ACT_W  = 5;
    localparam int CNT_W  = 32;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;

    // Result queue depth
    localparam int OUT_FIFO_DEPTH = 4;

    // Request kinds carried on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENTRY   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONTENT = 2'd2;

    // Table load broadcast to the entry cells
    typedef struct packed {
        logic              pat_we;
        logic              len_we;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  pos;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } load_req_t;

    // One scan report
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  entry;
        logic [CODE_W-1:0] threat;
        logic [CNT_W-1:0]  scans;
        logic [CNT_W-1:0]  threats;
    } result_t;

endpackage

>>> hw/rtl/msbs_window_chain.sv
module msbs_window_chain #(
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            shift_en,
    input  logic [7:0]                      in_byte,
    output logic [MAX_PATTERN_LEN-1:0][7:0] taps
);
    import msbs_pkg::*;

    logic [MAX_PATTERN_LEN-1:0][7:0] tap_reg;
    logic [MAX_PATTERN_LEN-1:0][7:0] tap_next;

    // Each byte cell takes its left neighbor's byte; tap 0 holds the newest byte
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign tap_next[k] = in_byte;
            end else begin : g_body
                assign tap_next[k] = tap_reg[k-1];
            end

            always_ff @(posedge aclk) begin
                if (shift_en) begin
                    tap_reg[k] <= tap_next[k];
                end
            end
        end
    endgenerate

    assign taps = tap_reg;

endmodule

>>> hw/rtl/msbs_entry_cell.sv
module msbs_entry_cell #(
    parameter int CELL_ID         = 0,
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF,
    parameter int SEEN_W          = 11
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msbs_pkg::load_req_t              load_req,
    input  logic [msbs_pkg::ACT_W-1:0]       active_signatures,
    input  logic [MAX_PATTERN_LEN-1:0][7:0]  window,
    input  logic [SEEN_W-1:0]                bytes_seen,
    input  logic                             cmp_vld,
    input  logic                             scan_end,
    output logic                             hit_now,
    output logic [msbs_pkg::CODE_W-1:0]      threat
);
    import msbs_pkg::*;

    localparam int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [MAX_PATTERN_LEN-1:0][7:0] pattern_reg;
    logic [LEN_W-1:0]                len_reg;
    logic [LEN_W-1:0]                len_next;
    logic [CODE_W-1:0]               threat_reg;
    logic [CODE_W-1:0]               threat_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic                            sel;
    logic                            active;
    logic                            match;

    assign sel    = (int'(load_req.idx) == CELL_ID);
    assign active = (CELL_ID < int'(active_signatures));

    // Pattern bytes: undefined until written
    always_ff @(posedge aclk) begin
        for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (load_req.pat_we && sel && (int'(load_req.pos) == p)) begin
                pattern_reg[p] <= load_req.data;
            end
        end
    end

    // Compare pattern byte p against the byte len-1-p places back
    always_comb begin
        int j;
        j     = 0;
        match = (len_reg != '0) && (int'(len_reg) <= MAX_PATTERN_LEN) &&
                (int'(bytes_seen) >= int'(len_reg));
        for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            j = int'(len_reg) - 1 - p;
            if (p < int'(len_reg)) begin
                if (pattern_reg[p] != window[j[PW-1:0]]) begin
                    match = 1'b0;
                end
            end
        end
    end

    assign hit_now = hit_reg | (cmp_vld & active & match);

    always_comb begin
        len_next    = len_reg;
        threat_next = threat_reg;
        if (load_req.len_we && sel) begin
            len_next    = load_req.len;
            threat_next = load_req.code;
        end
        hit_next = scan_end ? 1'b0 : hit_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            threat_reg <= '0;
            hit_reg    <= 1'b0;
        end else begin
            len_reg    <= len_next;
            threat_reg <= threat_next;
            hit_reg    <= hit_next;
        end
    end

    assign threat = threat_reg;

endmodule

>>> hw/rtl/msbs_out_fifo.sv
module msbs_out_fifo #(
    parameter int DEPTH = msbs_pkg::OUT_FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  msbs_pkg::result_t              wr_data,
    output logic                           rd_valid,
    input  logic                           rd_ready,
    output msbs_pkg::result_t              rd_data,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import msbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid & rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/multi_signature_byte_scanner.sv
// Signature scanner: holds a table of byte signatures and checks a content stream
// against all of them at once.
// s_ channel carries requests: pattern byte writes, entry length/threat writes and
// content bytes (kind on s_tuser, end of scan on s_tlast). APB register 0 at byte
// address 0 sets how many entries, lowest first, take part in matching.
// m_ channel carries one report per scan, issued for the content byte with tlast.
// Throughput: one request per cycle, any mix of kinds, while s_tready is high.
// The final byte is registered into the compare stage, where every entry cell compares
// against the byte window and the hits are snapshot; the pick stage then picks the
// lowest hit, updates the scan and threat counters and writes the report to the queue.
// The rate is set by the byte window chain shifting once per content byte while all
// entry cells compare in parallel.
// Reports wait in a four-deep queue; s_tready drops only when that queue, plus
// reports still in flight, would fill, so a stalled receiver holds the scanner after
// a few queued reports and nothing is lost.
// Reset (synchronous, aresetn low) clears lengths, threat codes, hit flags, counters,
// the register and the queue; pattern bytes keep whatever they held.
// Only the first MAX_SCAN_BYTES bytes of a scan are matched; later bytes are dropped
// but a tlast on them still ends the scan.
module multi_signature_byte_scanner #(
    parameter int NUM_ENTRIES     = msbs_pkg::NUM_ENTRIES_DEF,
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF,
    parameter int MAX_SCAN_BYTES  = msbs_pkg::MAX_SCAN_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] entry_index, [8:4] byte_position, [16:9] data_byte,
    // [22:17] pattern_length, [26:23] threat_code, [31:27] zero
    input  logic [msbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [msbs_pkg::FUNC_W-1:0]     s_tuser,
    input  logic                            s_tlast,
    // Report channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] matched_entry, [7:4] matched_threat, [39:8] scans_total,
    // [71:40] threats_total
    output logic [msbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] found
    output logic [0:0]                      m_tuser,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import msbs_pkg::*;

    localparam int SEEN_W = $clog2(MAX_SCAN_BYTES + 1);
    localparam int FCW    = $clog2(OUT_FIFO_DEPTH + 1);
    localparam logic REG_ACTIVE = 1'b0;

    logic [ACT_W-1:0]                active_reg;
    logic [ACT_W-1:0]                active_next;
    logic [SEEN_W-1:0]               bytes_seen_reg;
    logic [SEEN_W-1:0]               bytes_seen_next;
    logic [SEEN_W-1:0]               seen_base;
    logic                            scan_done_reg;
    logic                            scan_done_next;
    logic                            cmp_vld_reg;
    logic                            cmp_vld_next;
    logic                            rpt1_reg;
    logic                            rpt1_next;
    logic                            rpt2_reg;
    logic [NUM_ENTRIES-1:0]          snap_hits_reg;
    logic [NUM_ENTRIES-1:0][CODE_W-1:0] snap_threats_reg;
    logic [CNT_W-1:0]                scan_cnt_reg;
    logic [CNT_W-1:0]                scan_cnt_next;
    logic [CNT_W-1:0]                threat_cnt_reg;
    logic [CNT_W-1:0]                threat_cnt_next;

    logic                            s_acc;
    logic                            content;
    logic                            in_range;
    logic                            shift_en;
    logic                            cfg_wr;
    load_req_t                       load_req;
    logic [MAX_PATTERN_LEN-1:0][7:0] window;
    logic [NUM_ENTRIES-1:0]          hit_vec;
    logic [NUM_ENTRIES-1:0][CODE_W-1:0] threat_vec;
    result_t                         report;
    result_t                         fifo_out;
    logic [FCW-1:0]                  fifo_count;
    logic [FCW:0]                    pending;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_ACTIVE) ? 32'(active_reg) : 32'd0;

    always_comb begin
        active_next = active_reg;
        if (cfg_wr && (paddr[2] == REG_ACTIVE)) begin
            active_next = pwdata[ACT_W-1:0];
        end
    end

    // Hold requests while the report queue plus in-flight reports could fill it
    assign pending  = {1'b0, fifo_count} + (FCW+1)'(rpt1_reg) + (FCW+1)'(rpt2_reg);
    assign s_tready = (int'(pending) < OUT_FIFO_DEPTH);
    assign s_acc    = s_tvalid & s_tready;

    // Decode the request
    always_comb begin
        load_req.pat_we = s_acc && (s_tuser == FUNC_PATTERN);
        load_req.len_we = s_acc && (s_tuser == FUNC_ENTRY);
        load_req.idx    = s_tdata[3:0];
        load_req.pos    = s_tdata[8:4];
        load_req.data   = s_tdata[16:9];
        load_req.len    = s_tdata[22:17];
        load_req.code   = s_tdata[26:23];
    end

    assign content = s_acc && (s_tuser == FUNC_CONTENT);

    // A finished scan restarts the byte count at the next content byte
    assign seen_base = scan_done_reg ? '0 : bytes_seen_reg;
    assign in_range  = (int'(seen_base) < MAX_SCAN_BYTES);
    assign shift_en  = content & in_range;

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        scan_done_next  = scan_done_reg;
        if (content) begin
            bytes_seen_next = in_range ? seen_base + 1'b1 : seen_base;
            scan_done_next  = s_tlast;
        end
        cmp_vld_next = shift_en;
        rpt1_next    = content & s_tlast;
    end

    // Byte window: chain of byte cells
    msbs_window_chain #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_window (
        .aclk     (aclk),
        .shift_en (shift_en),
        .in_byte  (load_req.data),
        .taps     (window)
    );

    // One cell per table entry; each compares during the cycle after the byte
    genvar e;
    generate
        for (e = 0; e < NUM_ENTRIES; e++) begin : g_entry
            msbs_entry_cell #(
                .CELL_ID         (e),
                .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
                .SEEN_W          (SEEN_W)
            ) u_cell (
                .aclk              (aclk),
                .aresetn           (aresetn),
                .load_req          (load_req),
                .active_signatures (active_reg),
                .window            (window),
                .bytes_seen        (bytes_seen_reg),
                .cmp_vld           (cmp_vld_reg),
                .scan_end          (rpt1_reg),
                .hit_now           (hit_vec[e]),
                .threat            (threat_vec[e])
            );
        end
    endgenerate

    // Snapshot hits and threat codes as the scan ends, so later loads cannot leak in
    always_ff @(posedge aclk) begin
        if (rpt1_reg) begin
            snap_hits_reg    <= hit_vec;
            snap_threats_reg <= threat_vec;
        end
    end

    // Pick the lowest hit and advance the counters
    always_comb begin
        report.found  = 1'b0;
        report.entry  = '0;
        report.threat = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (snap_hits_reg[i]) begin
                report.found  = 1'b1;
                report.entry  = IDX_W'(i);
                report.threat = snap_threats_reg[i];
            end
        end
        scan_cnt_next   = scan_cnt_reg;
        threat_cnt_next = threat_cnt_reg;
        if (rpt2_reg) begin
            scan_cnt_next   = scan_cnt_reg + 1'b1;
            threat_cnt_next = threat_cnt_reg + CNT_W'(report.found);
        end
        report.scans   = scan_cnt_next;
        report.threats = threat_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            bytes_seen_reg <= '0;
            scan_done_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            rpt1_reg       <= 1'b0;
            rpt2_reg       <= 1'b0;
            scan_cnt_reg   <= '0;
            threat_cnt_reg <= '0;
        end else begin
            active_reg     <= active_next;
            bytes_seen_reg <= bytes_seen_next;
            scan_done_reg  <= scan_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            rpt1_reg       <= rpt1_next;
            rpt2_reg       <= rpt1_reg;
            scan_cnt_reg   <= scan_cnt_next;
            threat_cnt_reg <= threat_cnt_next;
        end
    end

    // Report queue
    msbs_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (rpt2_reg),
        .wr_data  (report),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (fifo_out),
        .count    (fifo_count)
    );

    assign m_tdata    = {fifo_out.threats, fifo_out.scans, fifo_out.threat, fifo_out.entry};
    assign m_tuser[0] = fifo_out.found;

`ifndef SYNTHESIS
    // Credit check must leave room for every report that reaches the queue
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        rpt2_reg |-> (int'(fifo_count) < OUT_FIFO_DEPTH))
        else $error("report queue overflow");

    // The pick stage only runs in the cycle after a scan end
    a_report_order: assert property (@(posedge aclk) disable iff (!aresetn)
        rpt2_reg |-> $past(rpt1_reg))
        else $error("report stage without scan end");

    // A compare always follows a counted content byte
    a_cmp_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (bytes_seen_reg != '0))
        else $error("compare without counted byte");

    // A clean report carries no entry and no threat code
    a_clean_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
        else $error("clean report with entry or threat set");
`endif

endmodule
